### src/rbi_pkg.sv
// Shared types, constants and the fixed-point product helper for the unit box intersect block.
// No dependencies; every other file in src refers to this package by scoped names.
package rbi_pkg;

	localparam int FRAC_BITS   = 16;
	localparam int COORD_WIDTH = 32;
	localparam int DIFF_W      = COORD_WIDTH + 1;
	localparam int PROD_W      = DIFF_W + COORD_WIDTH;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0]      diff_t;
	typedef logic signed [PROD_W-1:0]      prod_t;
	typedef logic [1:0]                    axis_t;

	localparam axis_t AXIS_X = 2'd0;
	localparam axis_t AXIS_Y = 2'd1;
	localparam axis_t AXIS_Z = 2'd2;

	// Box half extent, 0.5 in the fixed-point format.
	localparam diff_t HALF = diff_t'(1) <<< (FRAC_BITS - 1);

	localparam coord_t COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam coord_t COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

	// Slab distances found by one axis lane.
	typedef struct packed {
		coord_t t_near;
		coord_t t_far;
		logic   dir_neg;
	} lane_out_t;

	// Range and best distance carried alongside a request.
	typedef struct packed {
		coord_t t_min;
		coord_t t_max;
		coord_t best_t;
	} range_t;

	// Floor shift of a full product by the fraction width, saturated to a coordinate.
	function automatic coord_t sat_shift(input prod_t p);
		prod_t s;
		logic  fits;
		begin
			s = p >>> FRAC_BITS;
			fits = (&s[PROD_W-1:COORD_WIDTH-1]) || !(|s[PROD_W-1:COORD_WIDTH-1]);
			if (fits) begin
				return s[COORD_WIDTH-1:0];
			end else if (s[PROD_W-1]) begin
				return COORD_MIN;
			end else begin
				return COORD_MAX;
			end
		end
	endfunction

endpackage

### src/rbi_lane.sv
// One axis lane: slab offsets, full products with the inverse direction, floor and saturate.
// Depends on rbi_pkg. Three pipeline stages, no control state beyond the top level's valid chain.
module rbi_lane (
	input  logic                clk,
	input  rbi_pkg::coord_t     origin,
	input  rbi_pkg::coord_t     inv_dir,
	input  logic                dir_neg,
	output rbi_pkg::lane_out_t  bounds
);

	rbi_pkg::diff_t  origin_ext;
	rbi_pkg::diff_t  near_bound;
	rbi_pkg::diff_t  far_bound;
	rbi_pkg::diff_t  diff_near_s1;
	rbi_pkg::diff_t  diff_far_s1;
	rbi_pkg::coord_t inv_s1;
	logic            neg_s1;
	rbi_pkg::prod_t  prod_near_s2;
	rbi_pkg::prod_t  prod_far_s2;
	logic            neg_s2;
	rbi_pkg::coord_t t_near_s3;
	rbi_pkg::coord_t t_far_s3;
	logic            neg_s3;

	assign origin_ext = rbi_pkg::diff_t'(origin);
	// A negative direction swaps which slab plane is entered first.
	assign near_bound = dir_neg ? rbi_pkg::HALF : -rbi_pkg::HALF;
	assign far_bound  = dir_neg ? -rbi_pkg::HALF : rbi_pkg::HALF;

	always_ff @(posedge clk) begin
		diff_near_s1 <= near_bound - origin_ext;
		diff_far_s1  <= far_bound - origin_ext;
		inv_s1       <= inv_dir;
		neg_s1       <= dir_neg;

		prod_near_s2 <= diff_near_s1 * inv_s1;
		prod_far_s2  <= diff_far_s1 * inv_s1;
		neg_s2       <= neg_s1;

		t_near_s3    <= rbi_pkg::sat_shift(prod_near_s2);
		t_far_s3     <= rbi_pkg::sat_shift(prod_far_s2);
		neg_s3       <= neg_s2;
	end

	assign bounds.t_near  = t_near_s3;
	assign bounds.t_far   = t_far_s3;
	assign bounds.dir_neg = neg_s3;

endmodule

### src/rbi_merge.sv
// Merging stage: narrows the x interval by y and z, then picks the bound and checks the best distance.
// Depends on rbi_pkg; fed by three rbi_lane instances. Two register stages.
module rbi_merge (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid_s3,
	input  rbi_pkg::lane_out_t  lane_x,
	input  rbi_pkg::lane_out_t  lane_y,
	input  rbi_pkg::lane_out_t  lane_z,
	input  rbi_pkg::range_t     range_s3,
	output logic                done,
	output logic                hit,
	output rbi_pkg::coord_t     hit_t,
	output rbi_pkg::axis_t      normal_axis,
	output logic                normal_negative
);

	rbi_pkg::coord_t xn, xf, yn, yf, zn, zf;
	rbi_pkg::coord_t near1, far1, near2, far2;
	rbi_pkg::axis_t  axn1, axf1, axn2, axf2;
	logic            ngn1, ngf1, ngn2, ngf2;
	logic            reject;

	logic            valid_s4;
	logic            reject_s4;
	rbi_pkg::coord_t near_s4, far_s4;
	rbi_pkg::axis_t  ax_near_s4, ax_far_s4;
	logic            neg_near_s4, neg_far_s4;
	rbi_pkg::range_t range_s4;

	rbi_pkg::coord_t t_lo, t_hi, best;
	logic            ok_near, ok_far, have, take_near;
	rbi_pkg::coord_t t_pick;

	logic            done_q, hit_q, neg_q;
	rbi_pkg::coord_t t_q;
	rbi_pkg::axis_t  axis_q;

	always_comb begin
		xn = lane_x.t_near;
		xf = lane_x.t_far;
		yn = lane_y.t_near;
		yf = lane_y.t_far;
		zn = lane_z.t_near;
		zf = lane_z.t_far;

		// Narrow by y; ties keep the earlier axis since the compares are strict.
		near1 = xn;
		axn1  = rbi_pkg::AXIS_X;
		ngn1  = !lane_x.dir_neg;
		far1  = xf;
		axf1  = rbi_pkg::AXIS_X;
		ngf1  = lane_x.dir_neg;
		if (yn > xn) begin
			near1 = yn;
			axn1  = rbi_pkg::AXIS_Y;
			ngn1  = !lane_y.dir_neg;
		end
		if (yf < xf) begin
			far1 = yf;
			axf1 = rbi_pkg::AXIS_Y;
			ngf1 = lane_y.dir_neg;
		end

		near2 = near1;
		axn2  = axn1;
		ngn2  = ngn1;
		far2  = far1;
		axf2  = axf1;
		ngf2  = ngf1;
		if (zn > near1) begin
			near2 = zn;
			axn2  = rbi_pkg::AXIS_Z;
			ngn2  = !lane_z.dir_neg;
		end
		if (zf < far1) begin
			far2 = zf;
			axf2 = rbi_pkg::AXIS_Z;
			ngf2 = lane_z.dir_neg;
		end

		reject = (xn > yf) || (yn > xf) || (near1 > zf) || (zn > far1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		reject_s4   <= reject;
		near_s4     <= near2;
		far_s4      <= far2;
		ax_near_s4  <= axn2;
		ax_far_s4   <= axf2;
		neg_near_s4 <= ngn2;
		neg_far_s4  <= ngf2;
		range_s4    <= range_s3;
	end

	always_comb begin
		t_lo      = range_s4.t_min;
		t_hi      = range_s4.t_max;
		best      = range_s4.best_t;
		ok_near   = (near_s4 >= t_lo) && (near_s4 <= t_hi);
		ok_far    = (far_s4 >= t_lo) && (far_s4 <= t_hi);
		take_near = ok_near && (!ok_far || near_s4 <= far_s4);
		have      = !reject_s4 && (ok_near || ok_far);
		t_pick    = take_near ? near_s4 : far_s4;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s4;
		end
	end

	// A miss reports all fields as zero.
	always_ff @(posedge clk) begin
		if (have && (t_pick < best)) begin
			hit_q  <= 1'b1;
			t_q    <= t_pick;
			axis_q <= take_near ? ax_near_s4 : ax_far_s4;
			neg_q  <= take_near ? neg_near_s4 : neg_far_s4;
		end else begin
			hit_q  <= 1'b0;
			t_q    <= '0;
			axis_q <= rbi_pkg::AXIS_X;
			neg_q  <= 1'b0;
		end
	end

	assign done            = done_q;
	assign hit             = hit_q;
	assign hit_t           = t_q;
	assign normal_axis     = axis_q;
	assign normal_negative = neg_q;

endmodule

### src/ray_unit_box_intersect.sv
// Ray against unit box slab test. A request passes through the lane registers s1 to s3, then the
// merge registers s4 and the output register, and its result shows with done high.
// Throughput: one request per cycle; three axis lanes and the merge stages are fully pipelined,
// so busy is never asserted. The receiver cannot stall and takes each result as shown.
// Reset: arst_n clears the valid chain and done; the datapath registers are not reset.
// Depends on rbi_pkg, rbi_lane and rbi_merge.
module ray_unit_box_intersect (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  rbi_pkg::coord_t     origin_x,
	input  rbi_pkg::coord_t     origin_y,
	input  rbi_pkg::coord_t     origin_z,
	input  rbi_pkg::coord_t     inv_dir_x,
	input  rbi_pkg::coord_t     inv_dir_y,
	input  rbi_pkg::coord_t     inv_dir_z,
	input  logic                dir_neg_x,
	input  logic                dir_neg_y,
	input  logic                dir_neg_z,
	input  rbi_pkg::coord_t     t_min,
	input  rbi_pkg::coord_t     t_max,
	input  rbi_pkg::coord_t     current_best_t,
	output logic                done,
	output logic                hit,
	output rbi_pkg::coord_t     hit_t,
	output rbi_pkg::axis_t      normal_axis,
	output logic                normal_negative
);

	logic               accept;
	logic               valid_s1, valid_s2, valid_s3;
	rbi_pkg::range_t    range_in;
	rbi_pkg::range_t    range_s1, range_s2, range_s3;
	rbi_pkg::lane_out_t lane_x, lane_y, lane_z;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	assign range_in.t_min  = t_min;
	assign range_in.t_max  = t_max;
	assign range_in.best_t = current_best_t;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		range_s1 <= range_in;
		range_s2 <= range_s1;
		range_s3 <= range_s2;
	end

	rbi_lane u_lane_x (
		.clk     (clk),
		.origin  (origin_x),
		.inv_dir (inv_dir_x),
		.dir_neg (dir_neg_x),
		.bounds  (lane_x)
	);

	rbi_lane u_lane_y (
		.clk     (clk),
		.origin  (origin_y),
		.inv_dir (inv_dir_y),
		.dir_neg (dir_neg_y),
		.bounds  (lane_y)
	);

	rbi_lane u_lane_z (
		.clk     (clk),
		.origin  (origin_z),
		.inv_dir (inv_dir_z),
		.dir_neg (dir_neg_z),
		.bounds  (lane_z)
	);

	rbi_merge u_merge (
		.clk             (clk),
		.arst_n          (arst_n),
		.valid_s3        (valid_s3),
		.lane_x          (lane_x),
		.lane_y          (lane_y),
		.lane_z          (lane_z),
		.range_s3        (range_s3),
		.done            (done),
		.hit             (hit),
		.hit_t           (hit_t),
		.normal_axis     (normal_axis),
		.normal_negative (normal_negative)
	);

endmodule

### verif/testbench.sv
// Self-checking testbench for ray_unit_box_intersect: directed rays, then aimed and random rays.
// Each request is predicted by a local slab-test model, or takes the stated answer of a known
// directed row, and is checked against the done strobe. Depends on rbi_pkg and ray_unit_box_intersect.
`timescale 1ns / 100ps

module testbench;

	import rbi_pkg::*;

	localparam int     RANDOM_RAYS = 550;
	localparam int     CALM_TAIL   = 80;
	localparam int     CYCLE_LIMIT = 60000;
	localparam int     SETTLE      = 12;
	localparam coord_t ONE         = 32'sd65536;
	localparam coord_t HALF_T      = 32'sd32768;
	localparam longint BOX_HALF    = longint'(1) <<< (FRAC_BITS - 1);
	localparam coord_t ODD_VALUES [4] = '{32'sd0, COORD_MAX, COORD_MIN, -32'sd1};

	typedef struct packed {
		coord_t ox, oy, oz;
		coord_t ix, iy, iz;
		logic   nx, ny, nz;
		coord_t t_lo, t_hi, best;
	} ray_req_t;

	typedef struct packed {
		logic   hit;
		coord_t t;
		axis_t  axis;
		logic   neg;
	} box_hit_t;

	typedef struct packed {
		ray_req_t req;
		logic     known;
		box_hit_t want;
	} box_row_t;

	localparam box_hit_t NO_HIT = '0;

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   start = 1'b0;
	logic   busy;
	coord_t origin_x = '0, origin_y = '0, origin_z = '0;
	coord_t inv_dir_x = '0, inv_dir_y = '0, inv_dir_z = '0;
	logic   dir_neg_x = 1'b0, dir_neg_y = 1'b0, dir_neg_z = 1'b0;
	coord_t t_min = '0, t_max = '0, current_best_t = '0;
	logic   done;
	logic   hit;
	coord_t hit_t;
	axis_t  normal_axis;
	logic   normal_negative;

	// Typed expectation travels with the request it belongs to.
	logic     row_known = 1'b0;
	box_hit_t row_want = '0;

	box_hit_t pending_hits [$];
	int       mismatches = 0;
	int       cycle_count = 0;

	ray_unit_box_intersect u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.origin_x(origin_x), .origin_y(origin_y), .origin_z(origin_z),
		.inv_dir_x(inv_dir_x), .inv_dir_y(inv_dir_y), .inv_dir_z(inv_dir_z),
		.dir_neg_x(dir_neg_x), .dir_neg_y(dir_neg_y), .dir_neg_z(dir_neg_z),
		.t_min(t_min), .t_max(t_max), .current_best_t(current_best_t),
		.done(done), .hit(hit), .hit_t(hit_t), .normal_axis(normal_axis),
		.normal_negative(normal_negative)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic ray_req_t ray_of(coord_t ox, coord_t oy, coord_t oz,
			coord_t ix, coord_t iy, coord_t iz, logic nx, logic ny, logic nz,
			coord_t t_lo, coord_t t_hi, coord_t best);
		ray_req_t r;
		r = '{ox, oy, oz, ix, iy, iz, nx, ny, nz, t_lo, t_hi, best};
		return r;
	endfunction

	function automatic box_hit_t hit_of(logic h, coord_t t, axis_t axis, logic neg);
		box_hit_t b;
		b = '{h, t, axis, neg};
		return b;
	endfunction

	// Distance to one slab plane: floor of the Q16.16 product, clamped to a coordinate.
	function automatic coord_t slab_dist(input longint diff, input coord_t inv);
		logic signed [95:0] wide, w_inv, hi_lim, lo_lim;
		hi_lim = COORD_MAX;
		lo_lim = COORD_MIN;
		wide = diff;
		w_inv = inv;
		wide = (wide * w_inv) >>> FRAC_BITS;
		if (wide > hi_lim) begin
			return COORD_MAX;
		end else if (wide < lo_lim) begin
			return COORD_MIN;
		end
		return coord_t'(wide[COORD_WIDTH-1:0]);
	endfunction

	function automatic box_hit_t predict_box_hit(input ray_req_t r);
		localparam axis_t LANE_AXIS [3] = '{AXIS_X, AXIS_Y, AXIS_Z};
		coord_t org [3];
		coord_t inv [3];
		logic   neg [3];
		coord_t tn, tf, t_near, t_far, t_pick;
		longint bound;
		axis_t  ax_near, ax_far, ax_pick;
		logic   n_near, n_far, n_pick, ok_near, ok_far, have;
		org = '{r.ox, r.oy, r.oz};
		inv = '{r.ix, r.iy, r.iz};
		neg = '{r.nx, r.ny, r.nz};
		t_near = '0;
		t_far = '0;
		ax_near = AXIS_X;
		ax_far = AXIS_X;
		n_near = 1'b0;
		n_far = 1'b0;
		for (int a = 0; a < 3; a++) begin
			bound = neg[a] ? BOX_HALF : -BOX_HALF;
			tn = slab_dist(bound - longint'(org[a]), inv[a]);
			tf = slab_dist(-bound - longint'(org[a]), inv[a]);
			if (a == 0) begin
				t_near = tn;
				t_far = tf;
				n_near = !neg[a];
				n_far = neg[a];
			end else begin
				// Empty interval: the ray misses before the range is looked at.
				if (t_near > tf || tn > t_far) begin
					return NO_HIT;
				end
				if (tn > t_near) begin
					t_near = tn;
					ax_near = LANE_AXIS[a];
					n_near = !neg[a];
				end
				if (tf < t_far) begin
					t_far = tf;
					ax_far = LANE_AXIS[a];
					n_far = neg[a];
				end
			end
		end
		ok_near = t_near >= r.t_lo && t_near <= r.t_hi;
		ok_far = t_far >= r.t_lo && t_far <= r.t_hi;
		have = 1'b1;
		t_pick = t_far;
		ax_pick = ax_far;
		n_pick = n_far;
		if (ok_near && (!ok_far || t_near <= t_far)) begin
			t_pick = t_near;
			ax_pick = ax_near;
			n_pick = n_near;
		end else if (!ok_far) begin
			have = 1'b0;
		end
		if (have && t_pick < r.best) begin
			return hit_of(1'b1, t_pick, ax_pick, n_pick);
		end
		return NO_HIT;
	endfunction

	// A ray from a random origin toward a random point in or near the box.
	function automatic ray_req_t aimed_ray();
		coord_t o [3];
		coord_t iv [3];
		logic   ng [3];
		longint org, aim, d, q, spread;
		coord_t t_lo, t_hi, best;
		spread = ($urandom_range(0, 7) == 0) ? 64'sd4194304 : 64'sd262144;
		for (int a = 0; a < 3; a++) begin
			org = longint'($urandom_range(0, 2 * spread)) - spread;
			aim = longint'($urandom_range(0, 98304)) - 49152;
			d = aim - org;
			if (d == 0) begin
				q = longint'(COORD_MAX);
			end else begin
				q = 64'sd4294967296 / d;
			end
			if (q > longint'(COORD_MAX)) begin
				q = longint'(COORD_MAX);
			end else if (q < longint'(COORD_MIN)) begin
				q = longint'(COORD_MIN);
			end
			o[a] = coord_t'(org);
			iv[a] = coord_t'(q);
			ng[a] = d < 0;
		end
		case ($urandom_range(0, 3))
			0: t_lo = '0;
			1: t_lo = coord_t'(longint'($urandom_range(0, 262144)) - 131072);
			2: t_lo = COORD_MIN;
			default: t_lo = coord_t'($urandom_range(0, 262144));
		endcase
		t_hi = ($urandom_range(0, 3) == 0) ? coord_t'($urandom_range(0, 1048576)) : COORD_MAX;
		best = $urandom_range(0, 1) ? coord_t'($urandom_range(0, 524288)) : COORD_MAX;
		return ray_of(o[0], o[1], o[2], iv[0], iv[1], iv[2], ng[0], ng[1], ng[2],
			t_lo, t_hi, best);
	endfunction

	// An aimed ray with one part spoiled: sign bits, range order, or fields set to odd or extreme values.
	function automatic ray_req_t broken_ray();
		ray_req_t r;
		logic [2:0] mask;
		coord_t swap;
		r = aimed_ray();
		case ($urandom_range(0, 3))
			0: begin
				mask = 3'($urandom_range(1, 7));
				r.nx ^= mask[0];
				r.ny ^= mask[1];
				r.nz ^= mask[2];
			end
			1: begin
				swap = r.t_lo;
				r.t_lo = r.t_hi;
				r.t_hi = swap;
			end
			2: begin
				r.ix = ODD_VALUES[$urandom_range(0, 3)];
				r.iz = ODD_VALUES[$urandom_range(0, 3)];
			end
			default: begin
				r.oy = ODD_VALUES[$urandom_range(0, 3)];
				r.best = ODD_VALUES[$urandom_range(0, 3)];
			end
		endcase
		return r;
	endfunction

	function automatic ray_req_t noise_ray();
		return ray_of($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			1'($urandom), 1'($urandom), 1'($urandom), $urandom, $urandom, $urandom);
	endfunction

	task automatic issue(input ray_req_t r, input logic known, input box_hit_t want);
		logic took;
		origin_x <= r.ox;
		origin_y <= r.oy;
		origin_z <= r.oz;
		inv_dir_x <= r.ix;
		inv_dir_y <= r.iy;
		inv_dir_z <= r.iz;
		dir_neg_x <= r.nx;
		dir_neg_y <= r.ny;
		dir_neg_z <= r.nz;
		t_min <= r.t_lo;
		t_max <= r.t_hi;
		current_best_t <= r.best;
		row_known <= known;
		row_want <= want;
		start <= 1'b1;
		took = 1'b0;
		while (!took) begin
			@(negedge clk);
			took = !busy;
			@(posedge clk);
		end
	endtask

	task automatic pause_sender(input int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic wait_for_results();
		start <= 1'b0;
		do @(negedge clk); while (pending_hits.size() != 0);
		@(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && start && !busy) begin
			pending_hits.push_back(row_known ? row_want : predict_box_hit(ray_of(
				origin_x, origin_y, origin_z, inv_dir_x, inv_dir_y, inv_dir_z,
				dir_neg_x, dir_neg_y, dir_neg_z, t_min, t_max, current_best_t)));
		end
	end

	always @(posedge clk) begin
		box_hit_t exp_hit;
		if (arst_n && done) begin
			if (pending_hits.size() == 0) begin
				$error("result arrived with no request outstanding");
				mismatches++;
			end else begin
				exp_hit = pending_hits.pop_front();
				if (hit !== exp_hit.hit) begin
					$error("hit: expected %0d, got %0d", exp_hit.hit, hit);
					mismatches++;
				end
				if (hit_t !== exp_hit.t) begin
					$error("hit_t: expected %0d, got %0d", exp_hit.t, hit_t);
					mismatches++;
				end
				if (normal_axis !== exp_hit.axis) begin
					$error("normal_axis: expected %0d, got %0d", exp_hit.axis, normal_axis);
					mismatches++;
				end
				if (normal_negative !== exp_hit.neg) begin
					$error("normal_negative: expected %0d, got %0d", exp_hit.neg,
						normal_negative);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		box_row_t dir_rows [$];
		ray_req_t req;
		int       pick;
		logic     calm;

		// Rays with known answers first, mostly from the center, where the answer is plain.
		dir_rows.push_back('{ray_of(0, 0, 0, ONE, ONE, ONE, 0, 0, 0, 0, COORD_MAX, COORD_MAX),
			1'b1, hit_of(1'b1, HALF_T, AXIS_X, 1'b0)});
		dir_rows.push_back('{ray_of(0, 0, 0, ONE, ONE, ONE, 0, 0, 0, COORD_MIN, COORD_MAX,
			COORD_MAX), 1'b1, hit_of(1'b1, -HALF_T, AXIS_X, 1'b1)});
		dir_rows.push_back('{ray_of(0, 0, 0, ONE, ONE, ONE, 0, 0, 0, 0, COORD_MAX, HALF_T),
			1'b1, NO_HIT});
		dir_rows.push_back('{ray_of(0, 0, 0, ONE, ONE, ONE, 0, 0, 0, HALF_T, HALF_T,
			COORD_MAX), 1'b1, hit_of(1'b1, HALF_T, AXIS_X, 1'b0)});
		dir_rows.push_back('{ray_of(0, 0, 0, ONE, ONE, ONE, 0, 0, 0, ONE, 0, COORD_MAX),
			1'b1, NO_HIT});
		dir_rows.push_back('{ray_of(0, -3 * ONE, 0, ONE, ONE, ONE, 0, 0, 0, 0, COORD_MAX,
			COORD_MAX), 1'b1, NO_HIT});
		dir_rows.push_back('{ray_of(0, 0, 0, -ONE, -ONE, -ONE, 1, 1, 1, 0, COORD_MAX,
			COORD_MAX), 1'b1, hit_of(1'b1, HALF_T, AXIS_X, 1'b1)});
		dir_rows.push_back('{ray_of(0, 0, 0, ONE, ONE, ONE, 1, 1, 1, COORD_MIN, COORD_MAX,
			COORD_MAX), 1'b1, NO_HIT});
		dir_rows.push_back('{ray_of(0, -ONE, 0, ONE, ONE, ONE, 0, 0, 0, 0, COORD_MAX,
			COORD_MAX), 1'b1, hit_of(1'b1, HALF_T, AXIS_Y, 1'b1)});
		dir_rows.push_back('{ray_of(0, 0, -ONE, ONE, ONE, ONE, 0, 0, 0, 0, COORD_MAX,
			COORD_MAX), 1'b1, hit_of(1'b1, HALF_T, AXIS_Z, 1'b1)});
		dir_rows.push_back('{ray_of(0, 0, 0, 0, 0, 0, 0, 0, 0, COORD_MIN, COORD_MAX,
			COORD_MAX), 1'b1, hit_of(1'b1, 0, AXIS_X, 1'b1)});
		dir_rows.push_back('{ray_of(0, 0, 0, ONE, ONE, ONE, 0, 0, 0, COORD_MIN, COORD_MAX,
			COORD_MIN), 1'b1, NO_HIT});
		// Saturating products, far faces and mixed signs go through the predictor.
		dir_rows.push_back('{ray_of(0, 0, ONE, ONE, ONE, ONE, 0, 0, 0, COORD_MIN, COORD_MAX,
			COORD_MAX), 1'b0, NO_HIT});
		dir_rows.push_back('{ray_of(0, 0, 0, COORD_MAX, COORD_MAX, -ONE, 0, 0, 1, 0,
			COORD_MAX, COORD_MAX), 1'b0, NO_HIT});
		dir_rows.push_back('{ray_of(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
			COORD_MAX, 0, 0, 0, COORD_MIN, COORD_MAX, COORD_MAX), 1'b0, NO_HIT});
		dir_rows.push_back('{ray_of(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
			COORD_MIN, 1, 1, 1, COORD_MIN, COORD_MAX, COORD_MAX), 1'b0, NO_HIT});
		dir_rows.push_back('{ray_of(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX,
			COORD_MIN, 1, 0, 1, COORD_MIN, COORD_MAX, COORD_MAX), 1'b0, NO_HIT});
		dir_rows.push_back('{ray_of(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN,
			COORD_MAX, 0, 1, 0, COORD_MIN, COORD_MIN, COORD_MAX), 1'b0, NO_HIT});
		dir_rows.push_back('{ray_of(-1, -1, -1, -1, -1, -1, 1, 1, 1, COORD_MIN, COORD_MAX,
			COORD_MAX), 1'b0, NO_HIT});
		dir_rows.push_back('{ray_of(-2 * ONE, -3 * ONE / 2, -ONE, ONE / 2, 2 * ONE / 3, ONE,
			0, 0, 0, 0, 4 * ONE, COORD_MAX), 1'b0, NO_HIT});
		dir_rows.push_back('{ray_of(3 * ONE, 2 * ONE, -4 * ONE, -ONE / 3, -ONE / 2, ONE / 4,
			1, 1, 0, 0, COORD_MAX, 5 * ONE), 1'b0, NO_HIT});
		dir_rows.push_back('{ray_of(0, 0, 0, ONE, -ONE, ONE, 0, 1, 0, COORD_MAX, COORD_MAX,
			COORD_MAX), 1'b0, NO_HIT});

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if ($urandom_range(0, 3) == 0) begin
				pause_sender($urandom_range(1, 8));
			end
			issue(dir_rows[i].req, dir_rows[i].known, dir_rows[i].want);
		end

		for (int i = 0; i < RANDOM_RAYS; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 75) begin
				req = aimed_ray();
			end else if (pick < 88) begin
				req = broken_ray();
			end else begin
				req = noise_ray();
			end
			calm = ((i / 40) % 3 == 2) || (i >= RANDOM_RAYS - CALM_TAIL);
			if (!calm && $urandom_range(0, 3) == 0) begin
				pause_sender($urandom_range(1, 8));
			end
			if (i == RANDOM_RAYS / 2) begin
				wait_for_results();
			end
			issue(req, 1'b0, NO_HIT);
		end

		wait_for_results();
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
